// ===== hw/rtl/tlbcr_pkg.sv =====
`default_nettype none
package tlbcr_pkg;

	// Default buffer depth
	localparam int DEF_NUM_ENTRIES = 16;

	// Field widths
	localparam int KIND_W  = 3;
	localparam int PAGE_W  = 21;
	localparam int RKIND_W = 2;

	// Input beat kinds
	localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLR_REF = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INVAL   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_WB      = 3'd5;

	// Result beat kinds
	localparam logic [RKIND_W-1:0] RK_LOOKUP = 2'd0;
	localparam logic [RKIND_W-1:0] RK_EVICT  = 2'd1;
	localparam logic [RKIND_W-1:0] RK_WB     = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic cap;      // latch the input beat
		logic cmp;      // parallel page compare for lookup
		logic lk_resp;  // resolve lookup and reply
		logic ins_step; // one step of the clock search
		logic wb_step;  // one step of the write-back walk
		logic flush;    // clear all valid bits
		logic clr_ref;  // clear all reference bits
		logic inval;    // invalidate matching pages
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic ins_done; // victim chosen this cycle
		logic wb_done;  // walk is at the final entry
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tlbcr_ctrl.sv =====
`default_nettype none
module tlbcr_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tlbcr_pkg::KIND_W-1:0] kind,
	input  wire tlbcr_pkg::status_t           status,
	output tlbcr_pkg::cmd_t                   cmd,
	output logic                              busy
);
	import tlbcr_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_LK_CMP  = 8'b0000_0010,
		S_LK_RESP = 8'b0000_0100,
		S_INS     = 8'b0000_1000,
		S_WB      = 8'b0001_0000,
		S_FLUSH   = 8'b0010_0000,
		S_CLR     = 8'b0100_0000,
		S_INVAL   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_LOOKUP:  state_d = S_LK_CMP;
						KIND_INSERT:  state_d = S_INS;
						KIND_FLUSH:   state_d = S_FLUSH;
						KIND_CLR_REF: state_d = S_CLR;
						KIND_INVAL:   state_d = S_INVAL;
						KIND_WB:      state_d = S_WB;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_LK_CMP:  state_d = S_LK_RESP;
			S_LK_RESP: state_d = S_IDLE;
			S_INS:     state_d = status.ins_done ? S_IDLE : S_INS;
			S_WB:      state_d = status.wb_done ? S_IDLE : S_WB;
			S_FLUSH:   state_d = S_IDLE;
			S_CLR:     state_d = S_IDLE;
			S_INVAL:   state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.cap      = accept;
		cmd.cmp      = (state_q == S_LK_CMP);
		cmd.lk_resp  = (state_q == S_LK_RESP);
		cmd.ins_step = (state_q == S_INS);
		cmd.wb_step  = (state_q == S_WB);
		cmd.flush    = (state_q == S_FLUSH);
		cmd.clr_ref  = (state_q == S_CLR);
		cmd.inval    = (state_q == S_INVAL);
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tlbcr_dp.sv =====
`default_nettype none
module tlbcr_dp #(
	parameter int NUM_ENTRIES = tlbcr_pkg::DEF_NUM_ENTRIES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tlbcr_pkg::cmd_t               cmd,
	output tlbcr_pkg::status_t                 status,
	input  wire logic [tlbcr_pkg::KIND_W-1:0]  kind,
	input  wire logic [tlbcr_pkg::PAGE_W-1:0]  vpage,
	input  wire logic [tlbcr_pkg::PAGE_W-1:0]  frame,
	input  wire logic                          is_store,
	output logic                               strobe,
	output logic [tlbcr_pkg::RKIND_W-1:0]      reply_kind,
	output logic                               hit,
	output logic [tlbcr_pkg::PAGE_W-1:0]       frame_out,
	output logic                               ref_bit,
	output logic                               mod_bit,
	output logic                               last
);
	import tlbcr_pkg::*;

	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

	// Entry storage
	logic [NUM_ENTRIES-1:0] valid_q, ref_q, mod_q;
	logic [PAGE_W-1:0]      vpage_q [NUM_ENTRIES];
	logic [PAGE_W-1:0]      frame_q [NUM_ENTRIES];
	logic [IW-1:0]          hand_q;

	// Latched request and walk state
	logic [PAGE_W-1:0]      req_vpage_q, req_frame_q;
	logic                   req_store_q;
	logic [IW-1:0]          idx_q, step_q;
	logic [NUM_ENTRIES-1:0] match_q;

	// Result register
	logic                   strobe_q;
	logic [RKIND_W-1:0]     rkind_q;
	logic                   hit_q, ref_out_q, mod_out_q, last_q;
	logic [PAGE_W-1:0]      frame_out_q;

	logic                   hit_any, cand, ins_done, wb_last;
	logic [IW-1:0]          hit_idx, victim;
	logic [NUM_ENTRIES-1:0] page_eq, above;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
		return (v == LAST_IDX) ? '0 : v + 1'b1;
	endfunction

	// Lowest-index hit among registered matches
	always_comb begin
		hit_idx = '0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = IW'(i);
			end
		end
	end
	assign hit_any = |match_q;

	// Clock search: test the entry under the walk index
	assign cand     = !valid_q[idx_q] || !ref_q[idx_q];
	assign victim   = cand ? idx_q : hand_q;
	assign ins_done = cand || (step_q == LAST_IDX);

	// Per-entry page compare and write-back tail test
	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			page_eq[i] = (vpage_q[i] == req_vpage_q);
			above[i]   = (IW'(i) > idx_q);
		end
	end
	assign wb_last = ~|(valid_q & above);

	assign status.ins_done = ins_done;
	assign status.wb_done  = (idx_q == LAST_IDX);

	// Request latch and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			step_q <= '0;
		end else begin
			if (cmd.cap) begin
				idx_q  <= (kind == KIND_WB) ? '0 : hand_q;
				step_q <= '0;
			end else if (cmd.ins_step && !ins_done) begin
				idx_q  <= wrap_inc(idx_q);
				step_q <= step_q + 1'b1;
			end else if (cmd.wb_step) begin
				idx_q  <= wrap_inc(idx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_vpage_q <= vpage;
			req_frame_q <= frame;
			req_store_q <= is_store;
		end
		if (cmd.cmp) begin
			match_q <= valid_q & page_eq;
		end
	end

	// Entry updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q   <= '0;
			mod_q   <= '0;
			hand_q  <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				vpage_q[i] <= '0;
				frame_q[i] <= '0;
			end
		end else begin
			if (cmd.lk_resp && hit_any) begin
				ref_q[hit_idx] <= 1'b1;
				if (req_store_q) begin
					mod_q[hit_idx] <= 1'b1;
				end
			end
			if (cmd.ins_step && ins_done) begin
				valid_q[victim] <= 1'b1;
				ref_q[victim]   <= 1'b1;
				mod_q[victim]   <= 1'b1;
				vpage_q[victim] <= req_vpage_q;
				frame_q[victim] <= req_frame_q;
				hand_q          <= wrap_inc(victim);
			end
			if (cmd.flush) begin
				valid_q <= '0;
			end
			if (cmd.clr_ref) begin
				ref_q <= '0;
			end
			if (cmd.inval) begin
				valid_q <= valid_q & ~page_eq;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.lk_resp
				|| (cmd.ins_step && ins_done && valid_q[victim])
				|| (cmd.wb_step && valid_q[idx_q]);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.lk_resp) begin
			rkind_q     <= RK_LOOKUP;
			hit_q       <= hit_any;
			frame_out_q <= hit_any ? frame_q[hit_idx] : '0;
			ref_out_q   <= hit_any;
			mod_out_q   <= hit_any && (mod_q[hit_idx] || req_store_q);
			last_q      <= 1'b1;
		end else if (cmd.ins_step) begin
			rkind_q     <= RK_EVICT;
			hit_q       <= 1'b0;
			frame_out_q <= frame_q[victim];
			ref_out_q   <= ref_q[victim];
			mod_out_q   <= mod_q[victim];
			last_q      <= 1'b1;
		end else if (cmd.wb_step) begin
			rkind_q     <= RK_WB;
			hit_q       <= 1'b0;
			frame_out_q <= frame_q[idx_q];
			ref_out_q   <= ref_q[idx_q];
			mod_out_q   <= mod_q[idx_q];
			last_q      <= wb_last;
		end
	end

	assign strobe     = strobe_q;
	assign reply_kind = rkind_q;
	assign hit        = hit_q;
	assign frame_out  = frame_out_q;
	assign ref_bit    = ref_out_q;
	assign mod_bit    = mod_out_q;
	assign last       = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tlb_with_clock_replacement_unit.sv =====
`default_nettype none
// Fully associative TLB with clock replacement.
// Command channel: a beat (kind, vpage, frame, is_store) is taken at a rising
// edge where start is high and busy is low; busy stays high while it runs.
// Result channel: each result beat sits on reply_kind/hit/frame_out/ref_bit/
// mod_bit/last for exactly one cycle with strobe high; last marks the final
// beat of a command. The receiver has no back-pressure and must take it.
// Command steps while busy: lookup runs a compare state then a reply state;
//   insert tests one ring entry per cycle from the hand, at most NUM_ENTRIES
//   of them; write back walks all NUM_ENTRIES (one entry walked per cycle);
//   flush, clear R and invalidate each run one state; undefined kinds never
//   raise busy. The controller's entry walk sets insert and write-back time.
// Result beats leave in the cycle after the cycle that produces them, so the
// final beat of a command can overlap the accept of the next one.
// Reset clears every entry (valid, page, frame, R, M) and the clock hand at
// once; the unit is idle and ready as soon as reset is released.
module tlb_with_clock_replacement_unit #(
	parameter int NUM_ENTRIES = tlbcr_pkg::DEF_NUM_ENTRIES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [tlbcr_pkg::KIND_W-1:0]  kind,
	input  wire logic [tlbcr_pkg::PAGE_W-1:0]  vpage,
	input  wire logic [tlbcr_pkg::PAGE_W-1:0]  frame,
	input  wire logic                          is_store,
	output logic                               strobe,
	output logic [tlbcr_pkg::RKIND_W-1:0]      reply_kind,
	output logic                               hit,
	output logic [tlbcr_pkg::PAGE_W-1:0]       frame_out,
	output logic                               ref_bit,
	output logic                               mod_bit,
	output logic                               last
);
	import tlbcr_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer
	tlbcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Entry store and result register
	tlbcr_dp #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.kind       (kind),
		.vpage      (vpage),
		.frame      (frame),
		.is_store   (is_store),
		.strobe     (strobe),
		.reply_kind (reply_kind),
		.hit        (hit),
		.frame_out  (frame_out),
		.ref_bit    (ref_bit),
		.mod_bit    (mod_bit),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== verif/tlb_with_clock_replacement_unit_tb.sv =====
module tlb_with_clock_replacement_unit_tb;
	import tlbcr_pkg::*;

	localparam int NE = DEF_NUM_ENTRIES;
	localparam logic [PAGE_W-1:0] PAGE_ALL = {PAGE_W{1'b1}};
	// Kinds outside the defined set; the unit must ignore them
	localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 2 * NE + 4;

	typedef struct {
		logic [RKIND_W-1:0] rkind;
		logic               hit;
		logic [PAGE_W-1:0]  frame;
		logic               r;
		logic               m;
		logic               last;
	} tlb_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [KIND_W-1:0]   kind = KIND_LOOKUP;
	logic [PAGE_W-1:0]   vpage = '0;
	logic [PAGE_W-1:0]   frame = '0;
	logic                is_store = 1'b0;
	wire                 busy;
	wire                 strobe;
	wire [RKIND_W-1:0]   reply_kind;
	wire                 hit;
	wire [PAGE_W-1:0]    frame_out;
	wire                 ref_bit;
	wire                 mod_bit;
	wire                 last;

	// Shadow copy of the buffer, updated as each command beat is taken
	logic                sh_valid [NE];
	logic [PAGE_W-1:0]   sh_page  [NE];
	logic [PAGE_W-1:0]   sh_frame [NE];
	logic                sh_ref   [NE];
	logic                sh_mod   [NE];
	int                  sh_hand;

	tlb_reply_t          pending_replies[$];
	logic [PAGE_W-1:0]   resident_pages[$];
	tlb_reply_t          want_reply;
	bit                  sender_idles = 1'b1;
	int                  fail_count;
	int                  cmds_taken;
	int                  beats_checked;
	int                  hits_seen;
	int                  evicts_seen;
	int                  wb_seen;
	int                  quiet_cycles;

	tlb_with_clock_replacement_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.vpage(vpage),
		.frame(frame),
		.is_store(is_store),
		.strobe(strobe),
		.reply_kind(reply_kind),
		.hit(hit),
		.frame_out(frame_out),
		.ref_bit(ref_bit),
		.mod_bit(mod_bit),
		.last(last)
	);

	always #5 clk = ~clk;

	// Shadow buffer matches the unit right after reset
	task automatic clear_shadow();
		foreach (sh_valid[i]) begin
			sh_valid[i] = 1'b0;
			sh_page[i]  = '0;
			sh_frame[i] = '0;
			sh_ref[i]   = 1'b0;
			sh_mod[i]   = 1'b0;
		end
		sh_hand = 0;
	endtask

	// Apply one taken command to the shadow buffer and queue its replies
	task automatic mirror_command(logic [KIND_W-1:0] k, logic [PAGE_W-1:0] vp,
			logic [PAGE_W-1:0] fr, logic st);
		int victim;
		int j;
		int last_idx;
		bit found;
		tlb_reply_t rep;
		rep = '{RK_LOOKUP, 1'b0, '0, 1'b0, 1'b0, 1'b1};
		case (k)
			KIND_LOOKUP: begin
				found = 1'b0;
				for (int i = 0; i < NE && !found; i++) begin
					if (sh_valid[i] && sh_page[i] == vp) begin
						found = 1'b1;
						sh_ref[i] = 1'b1;
						if (st)
							sh_mod[i] = 1'b1;
						rep = '{RK_LOOKUP, 1'b1, sh_frame[i], 1'b1, sh_mod[i], 1'b1};
					end
				end
				pending_replies.push_back(rep);
			end
			KIND_INSERT: begin
				// clock search: first invalid or unreferenced slot from the hand
				victim = sh_hand;
				found = 1'b0;
				for (int s = 0; s < NE && !found; s++) begin
					j = (sh_hand + s) % NE;
					if (!sh_valid[j] || !sh_ref[j]) begin
						victim = j;
						found = 1'b1;
					end
				end
				if (sh_valid[victim]) begin
					rep = '{RK_EVICT, 1'b0, sh_frame[victim], sh_ref[victim],
						sh_mod[victim], 1'b1};
					pending_replies.push_back(rep);
				end
				sh_valid[victim] = 1'b1;
				sh_page[victim]  = vp;
				sh_frame[victim] = fr;
				sh_ref[victim]   = 1'b1;
				sh_mod[victim]   = 1'b1;
				sh_hand = (victim + 1) % NE;
			end
			KIND_FLUSH:
				foreach (sh_valid[i]) sh_valid[i] = 1'b0;
			KIND_CLR_REF:
				foreach (sh_ref[i]) sh_ref[i] = 1'b0;
			KIND_INVAL:
				// stored page decides, valid or not
				foreach (sh_page[i]) if (sh_page[i] == vp) sh_valid[i] = 1'b0;
			KIND_WB: begin
				last_idx = -1;
				foreach (sh_valid[i]) if (sh_valid[i]) last_idx = i;
				foreach (sh_valid[i]) begin
					if (sh_valid[i]) begin
						rep = '{RK_WB, 1'b0, sh_frame[i], sh_ref[i], sh_mod[i],
							i == last_idx};
						pending_replies.push_back(rep);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Drive one command beat, hold it until taken, then update the shadow
	task automatic issue_command(logic [KIND_W-1:0] k, logic [PAGE_W-1:0] vp,
			logic [PAGE_W-1:0] fr, logic st);
		if (sender_idles && $urandom_range(0, 99) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start    <= 1'b1;
		kind     <= k;
		vpage    <= vp;
		frame    <= fr;
		is_store <= st;
		do @(posedge clk); while (busy);
		cmds_taken++;
		mirror_command(k, vp, fr, st);
		if (k == KIND_INSERT) begin
			resident_pages.push_back(vp);
			if (resident_pages.size() > 24)
				void'(resident_pages.pop_front());
		end
	endtask

	// Lower start and wait until every queued reply has come and the unit is idle
	task automatic drain_replies();
		start <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly pages already inserted, so lookups and invalidates land
	function automatic logic [PAGE_W-1:0] pick_page();
		logic [PAGE_W-1:0] p;
		p = PAGE_W'($urandom());
		if (resident_pages.size() != 0 && $urandom_range(0, 99) < 75)
			p = resident_pages[$urandom_range(0, resident_pages.size() - 1)];
		return p;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Reply checker: the unit cannot be stalled, so every strobe is a beat
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_replies.size() == 0) begin
				$error("reply beat with nothing expected: kind %0d frame %0h",
					reply_kind, frame_out);
				fail_count++;
			end else begin
				want_reply = pending_replies.pop_front();
				beats_checked++;
				check_field("reply_kind", want_reply.rkind, reply_kind);
				check_field("hit", want_reply.hit, hit);
				check_field("frame_out", want_reply.frame, frame_out);
				check_field("ref_bit", want_reply.r, ref_bit);
				check_field("mod_bit", want_reply.m, mod_bit);
				check_field("last", want_reply.last, last);
				if (want_reply.hit) hits_seen++;
				if (want_reply.rkind == RK_EVICT) evicts_seen++;
				if (want_reply.rkind == RK_WB) wb_seen++;
			end
		end
	end

	// Watchdog on cycles with neither a command taken nor a reply beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no activity for %0d cycles, %0d replies pending",
					quiet_cycles, pending_replies.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Field extremes, every kind, duplicates, invalidate and flush corners
	task automatic test_directed_basics();
		issue_command(KIND_LOOKUP, '0, '0, 1'b0);          // stored page 0 but invalid
		issue_command(KIND_WB, '0, '0, 1'b0);              // empty: no beats
		issue_command(KIND_INSERT, PAGE_ALL, PAGE_ALL, 1'b0);
		issue_command(KIND_INSERT, '0, '0, 1'b1);
		issue_command(KIND_INSERT, PAGE_ALL, 21'h0AAAAA, 1'b0); // duplicate page
		issue_command(KIND_LOOKUP, PAGE_ALL, '0, 1'b1);    // lowest index wins
		issue_command(KIND_LOOKUP, '0, PAGE_ALL, 1'b0);
		issue_command(KIND_LOOKUP, 21'h155555, '0, 1'b0);  // miss
		issue_command(KIND_WB, '0, '0, 1'b0);
		issue_command(KIND_CLR_REF, PAGE_ALL, PAGE_ALL, 1'b1);
		issue_command(KIND_LOOKUP, '0, '0, 1'b0);          // R set again, load
		issue_command(KIND_WB, '0, '0, 1'b0);
		issue_command(KIND_INVAL, PAGE_ALL, '0, 1'b0);     // hits both duplicates
		issue_command(KIND_LOOKUP, PAGE_ALL, '0, 1'b0);
		issue_command(KIND_RSVD6, 21'h155555, 21'h0AAAAA, 1'b1);
		issue_command(KIND_RSVD7, 21'h0AAAAA, 21'h155555, 1'b0);
		issue_command(KIND_INSERT, 21'h155555, 21'h155555, 1'b1);
		issue_command(KIND_WB, '0, '0, 1'b0);
		issue_command(KIND_FLUSH, '0, '0, 1'b0);
		issue_command(KIND_WB, '0, '0, 1'b0);
		issue_command(KIND_LOOKUP, 21'h155555, '0, 1'b1);  // flushed: miss
		issue_command(KIND_INSERT, 21'h0AAAAA, 21'h0AAAAA, 1'b0);
		issue_command(KIND_LOOKUP, 21'h0AAAAA, '0, 1'b1);
	endtask

	// Fill the ring, evict with all R set, then let the hand skip referenced slots
	task automatic test_clock_sweep();
		issue_command(KIND_FLUSH, '0, '0, 1'b0);
		repeat (NE + 4) issue_command(KIND_INSERT, PAGE_W'($urandom()),
			PAGE_W'($urandom()), 1'($urandom()));
		issue_command(KIND_CLR_REF, '0, '0, 1'b0);
		repeat (6) issue_command(KIND_LOOKUP, pick_page(), '0, 1'($urandom()));
		repeat (8) issue_command(KIND_INSERT, PAGE_W'($urandom()),
			PAGE_W'($urandom()), 1'b0);
		issue_command(KIND_WB, '0, '0, 1'b0);
	endtask

	// Weighted mix of well-formed traffic with some noise
	task automatic test_random_traffic(int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				issue_command(KIND_LOOKUP, pick_page(), PAGE_W'($urandom()),
					1'($urandom()));
			else if (pick < 70)
				issue_command(KIND_INSERT,
					($urandom_range(0, 9) == 0) ? pick_page() : PAGE_W'($urandom()),
					PAGE_W'($urandom()), 1'($urandom()));
			else if (pick < 76)
				issue_command(KIND_CLR_REF, PAGE_W'($urandom()), PAGE_W'($urandom()),
					1'($urandom()));
			else if (pick < 82)
				issue_command(KIND_INVAL, pick_page(), PAGE_W'($urandom()),
					1'($urandom()));
			else if (pick < 88)
				issue_command(KIND_WB, PAGE_W'($urandom()), PAGE_W'($urandom()),
					1'($urandom()));
			else if (pick < 91)
				issue_command(KIND_FLUSH, PAGE_W'($urandom()), PAGE_W'($urandom()),
					1'($urandom()));
			else if (pick < 94)
				issue_command($urandom_range(0, 1) ? KIND_RSVD6 : KIND_RSVD7,
					PAGE_W'($urandom()), PAGE_W'($urandom()), 1'($urandom()));
			else
				issue_command(KIND_LOOKUP, PAGE_W'($urandom()), PAGE_W'($urandom()),
					1'($urandom()));
		end
	endtask

	// Sender holds off until the unit has nothing outstanding
	task automatic test_pause_until_drained();
		issue_command(KIND_WB, '0, '0, 1'b0);
		drain_replies();
		issue_command(KIND_LOOKUP, pick_page(), '0, 1'b1);
	endtask

	initial begin
		clear_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_basics();
		test_clock_sweep();
		test_random_traffic(130);
		test_pause_until_drained();
		sender_idles = 1'b0;
		test_random_traffic(70);
		sender_idles = 1'b1;
		test_random_traffic(100);
		drain_replies();
		$display("covered %0d commands, %0d reply beats checked", cmds_taken, beats_checked);
		$display("  (%0d lookup hits, %0d evictions, %0d write-back beats)",
			hits_seen, evicts_seen, wb_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tlbcr_pkg.sv
hw/rtl/tlbcr_ctrl.sv
hw/rtl/tlbcr_dp.sv
hw/rtl/tlb_with_clock_replacement_unit.sv
verif/tlb_with_clock_replacement_unit_tb.sv
